FILE: design/sstp_pkg.sv
`default_nettype none

package sstp_pkg;

  // datapath widths
  localparam int unsigned XW             = 36;  // rotator vector, q16
  localparam int unsigned ZW             = 34;  // residual phase, 2^32 = 360 degrees
  localparam int unsigned PROD_W         = 46;  // distance times gain inverse
  localparam int unsigned ATAN_ENTRIES   = 24;
  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned TDATA_IN_W     = 16;
  localparam int unsigned TDATA_OUT_W    = 40;
  localparam int unsigned PT_W           = 17;

  localparam logic [29:0] KINV_Q30       = 30'd652032874;
  localparam logic signed [PT_W-1:0] OUT_LIMIT = 17'sd65535;

  // register reset values
  localparam logic [15:0] START_ANGLE_RST  = 16'h8000;
  localparam logic [15:0] ANGLE_STEP_RST   = 16'd91;
  localparam logic [15:0] SECTOR_BOUND_RST = 16'd24576;
  localparam logic [15:0] MIN_RANGE_RST    = 16'd120;
  localparam logic [15:0] MAX_RANGE_RST    = 16'd12000;

  typedef enum logic [2:0] {
    REG_START_ANGLE  = 3'd0,
    REG_ANGLE_STEP   = 3'd1,
    REG_SECTOR_BOUND = 3'd2,
    REG_MIN_RANGE    = 3'd3,
    REG_MAX_RANGE    = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] start_angle;
    logic [15:0] angle_step;
    logic [15:0] sector_bound;
    logic [15:0] min_range;
    logic [15:0] max_range;
  } cfg_t;

  // one item travelling down the rotator
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 keep;
    logic                 last;
  } rot_t;

  // atan(2^-i) in 2^32-per-turn units
  function automatic logic signed [ZW-1:0] atan_entry(input int unsigned idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:  v = 34'sd536870912;
      1:  v = 34'sd316933406;
      2:  v = 34'sd167458907;
      3:  v = 34'sd85004756;
      4:  v = 34'sd42667331;
      5:  v = 34'sd21354465;
      6:  v = 34'sd10679838;
      7:  v = 34'sd5340245;
      8:  v = 34'sd2670163;
      9:  v = 34'sd1335087;
      10: v = 34'sd667544;
      11: v = 34'sd333772;
      12: v = 34'sd166886;
      13: v = 34'sd83443;
      14: v = 34'sd41722;
      15: v = 34'sd20861;
      16: v = 34'sd10430;
      17: v = 34'sd5215;
      18: v = 34'sd2608;
      19: v = 34'sd1304;
      20: v = 34'sd652;
      21: v = 34'sd326;
      22: v = 34'sd163;
      23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: design/sstp_front.sv
`default_nettype none

module sstp_front
  import sstp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire logic [15:0] distance_i,
  input  wire logic        reading_valid_i,
  input  wire logic        scan_end_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output rot_t             data_o
);

  // stage a: angle, sector and range test, gain multiply
  logic [15:0]       offset_q, offset_d;
  logic              va_q, vb_q;
  logic              ready_b;
  logic [15:0]       ang;
  logic [16:0]       mag;
  logic              keep;
  logic [PROD_W-1:0] prod;
  logic [15:0]       ang_q;
  logic              flip_q, keep_q, last_q;
  logic [PROD_W-1:0] prod_q;
  logic              accept;

  // stage b: rounding, half-turn fold, residual phase
  logic [PROD_W-1:0] sum;
  logic [XW-1:0]     x0u;
  logic [15:0]       ang_r;
  rot_t              prep;
  rot_t              data_q;

  assign ang     = cfg_i.start_angle + offset_q;
  assign mag     = ang[15] ? (17'd0 - {ang[15], ang}) : {1'b0, ang};
  assign keep    = (mag >= {1'b0, cfg_i.sector_bound}) && reading_valid_i &&
                   (distance_i > cfg_i.min_range) && (distance_i < cfg_i.max_range);
  assign prod    = {30'd0, distance_i} * {16'd0, KINV_Q30};

  assign ready_b = ~vb_q | ready_i;
  assign ready_o = ~va_q | ready_b;
  assign accept  = valid_i & ready_o;

  assign offset_d = scan_end_i ? 16'd0 : offset_q + cfg_i.angle_step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      va_q     <= 1'b0;
      vb_q     <= 1'b0;
    end else begin
      if (accept) begin
        offset_q <= offset_d;
      end
      if (ready_o) begin
        va_q <= valid_i;
      end
      if (ready_b) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ang_q  <= ang;
      flip_q <= mag > 17'd16384;
      keep_q <= keep;
      last_q <= scan_end_i;
      prod_q <= prod;
    end
  end

  always_comb begin
    sum       = prod_q + PROD_W'(8192);
    x0u       = XW'(sum[PROD_W-1:14]);
    ang_r     = flip_q ? (ang_q ^ 16'h8000) : ang_q;
    prep.x    = flip_q ? -$signed(x0u) : $signed(x0u);
    prep.y    = '0;
    prep.z    = $signed({{(ZW-32){ang_r[15]}}, ang_r, 16'h0000});
    prep.keep = keep_q;
    prep.last = last_q;
  end

  always_ff @(posedge clk_i) begin
    if (va_q && ready_b) begin
      data_q <= prep;
    end
  end

  assign valid_o = vb_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

FILE: design/sstp_cell.sv
`default_nettype none

module sstp_cell
  import sstp_pkg::*;
#(
  parameter int unsigned SHIFT = 0
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic valid_i,
  output logic      ready_o,
  input  wire rot_t data_i,
  output logic      valid_o,
  input  wire logic ready_i,
  output rot_t      data_o
);

  localparam logic signed [ZW-1:0] Atan = atan_entry(SHIFT);

  logic signed [XW-1:0] dx, dy;
  logic                 up;
  rot_t                 step;
  logic                 v_q;
  rot_t                 data_q;

  assign dx = data_i.y >>> SHIFT;
  assign dy = data_i.x >>> SHIFT;
  assign up = ~data_i.z[ZW-1];

  always_comb begin
    step      = data_i;
    step.x    = up ? data_i.x - dx : data_i.x + dx;
    step.y    = up ? data_i.y + dy : data_i.y - dy;
    step.z    = up ? data_i.z - Atan : data_i.z + Atan;
  end

  assign ready_o = ~v_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= step;
    end
  end

  assign valid_o = v_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

FILE: design/sstp_finish.sv
`default_nettype none

module sstp_finish
  import sstp_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    valid_i,
  output logic                         ready_o,
  input  wire rot_t                    data_i,
  output logic                         m_tvalid_o,
  input  wire logic                    m_tready_i,
  output logic [TDATA_OUT_W-1:0]       m_tdata_o,
  output logic                         m_tuser_o,
  output logic                         m_tlast_o
);

  // round to millimetres and clamp
  function automatic logic [PT_W-1:0] to_mm(input logic signed [XW-1:0] v);
    logic signed [XW-1:0]    r;
    logic signed [XW-17:0]   q;
    logic [PT_W-1:0]         res;
    r = v + XW'(32768);
    q = r[XW-1:16];
    if (q > $signed((XW-16)'(OUT_LIMIT))) begin
      res = OUT_LIMIT;
    end else if (q < -$signed((XW-16)'(OUT_LIMIT))) begin
      res = -OUT_LIMIT;
    end else begin
      res = q[PT_W-1:0];
    end
    return res;
  endfunction

  logic                v_q;
  logic [PT_W-1:0]     px, py;
  logic [TDATA_OUT_W-1:0] tdata_q;
  logic                keep_q, last_q;

  assign px      = data_i.keep ? to_mm(data_i.x) : '0;
  assign py      = data_i.keep ? to_mm(data_i.y) : '0;
  assign ready_o = ~v_q | m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      tdata_q <= {(TDATA_OUT_W-2*PT_W)'(0), py, px};
      keep_q  <= data_i.keep;
      last_q  <= data_i.last;
    end
  end

  assign m_tvalid_o = v_q;
  assign m_tdata_o  = tdata_q;
  assign m_tuser_o  = keep_q;
  assign m_tlast_o  = last_q;

endmodule

`default_nettype wire

FILE: design/scan_sector_to_points_core.sv
`default_nettype none

// channel   | dir | signals                    | contents
// ----------+-----+----------------------------+----------------------------------------
// s stream  | in  | s_tvalid/tready/tdata/...  | one range sample per request
// m stream  | out | m_tvalid/tready/tdata/...  | keep flag and point per request
// config    | in  | cfg_we/cfg_idx/cfg_data    | five 16 bit registers, write only
//
// one request enters per cycle unless the output stalls; the path holds an accept stage with
// the gain multiply, a preparation stage, one rotator cell per stage and an output register
// reset clears all valid bits, the angle offset and the registers to their defaults
// every stage has its own valid bit: a stalled output holds only the stages behind it
// that are full, so bubbles close up and input is taken while a result waits

module scan_sector_to_points_core
  import sstp_pkg::*;
#(
  parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // input stream
  input  wire logic                   s_tvalid_i,
  output logic                        s_tready_o,
  input  wire logic [TDATA_IN_W-1:0]  s_tdata_i,   // [15:0] distance
  input  wire logic                   s_tuser_i,   // [0] reading_valid
  input  wire logic                   s_tlast_i,   // scan_end
  // output stream
  output logic                        m_tvalid_o,
  input  wire logic                   m_tready_i,
  output logic [TDATA_OUT_W-1:0]      m_tdata_o,   // [16:0] point_x, [33:17] point_y, zeros
  output logic                        m_tuser_o,   // [0] keep
  output logic                        m_tlast_o,   // end_of_scan
  // configuration
  input  wire logic                   cfg_we_i,
  input  wire logic [2:0]             cfg_idx_i,
  input  wire logic [15:0]            cfg_data_i
);

  // the arctangent table has 24 entries; more stages would add nothing
  localparam int unsigned NumStages =
    (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

  cfg_t cfg_q;

  // configuration registers, indexes beyond the list are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_angle  <= START_ANGLE_RST;
      cfg_q.angle_step   <= ANGLE_STEP_RST;
      cfg_q.sector_bound <= SECTOR_BOUND_RST;
      cfg_q.min_range    <= MIN_RANGE_RST;
      cfg_q.max_range    <= MAX_RANGE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START_ANGLE:  cfg_q.start_angle  <= cfg_data_i;
        REG_ANGLE_STEP:   cfg_q.angle_step   <= cfg_data_i;
        REG_SECTOR_BOUND: cfg_q.sector_bound <= cfg_data_i;
        REG_MIN_RANGE:    cfg_q.min_range    <= cfg_data_i;
        REG_MAX_RANGE:    cfg_q.max_range    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // chain links: index 0 leaves the front end, index NumStages enters the output stage
  logic [NumStages:0] chain_v;
  logic [NumStages:0] chain_r;
  rot_t               chain_data [NumStages+1];

  // angle tracking, sector and range test, initial vector
  sstp_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .valid_i         (s_tvalid_i),
    .ready_o         (s_tready_o),
    .distance_i      (s_tdata_i[15:0]),
    .reading_valid_i (s_tuser_i),
    .scan_end_i      (s_tlast_i),
    .valid_o         (chain_v[0]),
    .ready_i         (chain_r[0]),
    .data_o          (chain_data[0])
  );

  // row of rotator cells, cell k shifts by k
  for (genvar k = 0; k < NumStages; k++) begin : g_cell
    sstp_cell #(
      .SHIFT (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_v[k]),
      .ready_o (chain_r[k]),
      .data_i  (chain_data[k]),
      .valid_o (chain_v[k+1]),
      .ready_i (chain_r[k+1]),
      .data_o  (chain_data[k+1])
    );
  end

  // rounding, clamping and the output register
  sstp_finish u_finish (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (chain_v[NumStages]),
    .ready_o    (chain_r[NumStages]),
    .data_i     (chain_data[NumStages]),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

  // a dropped ray carries a zero point
  a_drop_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tuser_o |-> m_tdata_o == '0)
    else $error("dropped ray with nonzero point");

  // clamping never lets either coordinate reach -65536
  a_clamp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (m_tdata_o[16:0] != 17'h10000) && (m_tdata_o[33:17] != 17'h10000))
    else $error("point outside clamp range");

  // a full last cell that is held back keeps its item
  a_chain_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_v[NumStages] && !chain_r[NumStages] |=> chain_v[NumStages])
    else $error("rotator item lost under stall");

  // input is refused only while the output side is stalled
  a_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_o |-> m_tvalid_o && !m_tready_i)
    else $error("input refused without an output stall");

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps

import sstp_pkg::*;

typedef struct {
  logic        keep;
  logic [16:0] px;
  logic [16:0] py;
  logic        eos;
} ray_point_t;

class ray_point_tracker;
  logic [15:0] start_angle;
  logic [15:0] angle_step;
  logic [15:0] sector_bound;
  logic [15:0] min_range;
  logic [15:0] max_range;
  logic [15:0] offset;
  longint      atan_q32[24];
  int unsigned stages;
  ray_point_t  points_due[$];
  int unsigned errors;
  int unsigned checked;
  int unsigned kept;
  int unsigned scans;

  function new(int unsigned n_stages);
    atan_q32 = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                 10679838, 5340245, 2670163, 1335087, 667544, 333772,
                 166886, 83443, 41722, 20861, 10430, 5215,
                 2608, 1304, 652, 326, 163, 81};
    stages       = (n_stages > 24) ? 24 : n_stages;
    start_angle  = START_ANGLE_RST;
    angle_step   = ANGLE_STEP_RST;
    sector_bound = SECTOR_BOUND_RST;
    min_range    = MIN_RANGE_RST;
    max_range    = MAX_RANGE_RST;
    offset       = '0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      REG_START_ANGLE:  start_angle  = val;
      REG_ANGLE_STEP:   angle_step   = val;
      REG_SECTOR_BOUND: sector_bound = val;
      REG_MIN_RANGE:    min_range    = val;
      REG_MAX_RANGE:    max_range    = val;
      default: ;
    endcase
  endfunction

  function logic [16:0] round_sat(longint v);
    longint r;
    r = (v + 32768) >>> 16;
    if (r > 65535) r = 65535;
    if (r < -65535) r = -65535;
    return r[16:0];
  endfunction

  // rotate (range_mm, 0) by the binary angle, with a half turn folded out first
  function void cartesian_of(logic [15:0] range_mm, logic [15:0] ang, output logic [16:0] px,
                             output logic [16:0] py);
    int     sa;
    int     mag;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    sa  = shortint'(ang);
    mag = (sa < 0) ? -sa : sa;
    x   = (longint'(range_mm) * 652032874 + 8192) >>> 14;
    y   = 0;
    if (mag > 16384) begin
      x  = -x;
      sa = shortint'(ang ^ 16'h8000);
    end
    z = longint'(sa) * 65536;
    for (int i = 0; i < stages; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_q32[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_q32[i];
      end
    end
    px = round_sat(x);
    py = round_sat(y);
  endfunction

  function void note_ray(logic [15:0] range_mm, logic ok, logic tail);
    ray_point_t  want;
    logic [15:0] ang;
    int          sa;
    int          mag;
    ang  = start_angle + offset;
    sa   = shortint'(ang);
    mag  = (sa < 0) ? -sa : sa;
    want.keep = (mag >= int'(sector_bound)) && ok && (range_mm > min_range) &&
                (range_mm < max_range);
    want.px   = '0;
    want.py   = '0;
    want.eos  = tail;
    if (want.keep) begin
      cartesian_of(range_mm, ang, want.px, want.py);
      kept++;
    end
    points_due.push_back(want);
    if (tail) begin
      offset = '0;
      scans++;
    end else begin
      offset = offset + angle_step;
    end
  endfunction

  function void check_point(logic keep, logic [16:0] px, logic [16:0] py, logic eos);
    ray_point_t want;
    if (points_due.size() == 0) begin
      $display("%0t unexpected point: keep %0d x %0d y %0d eos %0d",
               $time, keep, $signed(px), $signed(py), eos);
      errors++;
      return;
    end
    want = points_due.pop_front();
    checked++;
    if (keep !== want.keep) begin
      $display("%0t keep mismatch: expected %0d actual %0d", $time, want.keep, keep);
      errors++;
    end
    if (px !== want.px) begin
      $display("%0t point_x mismatch: expected %0d actual %0d",
               $time, $signed(want.px), $signed(px));
      errors++;
    end
    if (py !== want.py) begin
      $display("%0t point_y mismatch: expected %0d actual %0d",
               $time, $signed(want.py), $signed(py));
      errors++;
    end
    if (eos !== want.eos) begin
      $display("%0t end_of_scan mismatch: expected %0d actual %0d", $time, want.eos, eos);
      errors++;
    end
  endfunction

  function int unsigned outstanding();
    return points_due.size();
  endfunction
endclass

module testbench;

  localparam int unsigned N_STAGES  = CORDIC_STAGES_DEF;
  localparam int unsigned LATENCY   = N_STAGES + 3;
  localparam int unsigned N_PHASES  = 10;
  localparam int unsigned PHASE_LEN = 153;
  // register indexes the block has no register behind
  localparam logic [2:0]  REG_SPARE_LO = 3'd5;
  localparam logic [2:0]  REG_SPARE_HI = 3'd7;

  logic                   clk_i;
  logic                   rst_ni     = 1'b0;
  logic                   s_tvalid_i = 1'b0;
  logic                   s_tready_o;
  logic [TDATA_IN_W-1:0]  s_tdata_i  = '0;   // [15:0] distance
  logic                   s_tuser_i  = 1'b0; // [0] reading_valid
  logic                   s_tlast_i  = 1'b0; // scan_end
  logic                   m_tvalid_o;
  logic                   m_tready_i = 1'b1;
  logic [TDATA_OUT_W-1:0] m_tdata_o;         // [16:0] point_x, [33:17] point_y, zeros
  logic                   m_tuser_o;         // [0] keep
  logic                   m_tlast_o;         // end_of_scan
  logic                   cfg_we_i   = 1'b0;
  logic [2:0]             cfg_idx_i  = '0;
  logic [15:0]            cfg_data_i = '0;

  int unsigned idle_pct  = 0;  // chance of a gap before each request
  int unsigned stall_pct = 0;  // chance of the sink starting a stall
  int unsigned settings_loaded = 0;

  ray_point_tracker tracker = new(N_STAGES);

  scan_sector_to_points_core #(
    .CORDIC_STAGES (N_STAGES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .s_tlast_i  (s_tlast_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap(int unsigned pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  // both handshakes are sampled on the edge, before any new drive lands
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_o) tracker.note_ray(s_tdata_i[15:0], s_tuser_i, s_tlast_i);
      if (m_tvalid_o && m_tready_i)
        tracker.check_point(m_tuser_o, m_tdata_o[16:0], m_tdata_o[33:17], m_tlast_o);
    end
  end

  // sink back-pressure
  initial begin : sink
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold == 0) hold = pick_gap(stall_pct);
      if (hold != 0) begin
        m_tready_i <= 1'b0;
        hold--;
      end else begin
        m_tready_i <= 1'b1;
      end
    end
  end

  // one range sample, held until the block takes it
  task automatic send_ray(input logic [15:0] range_mm, input logic ok, input logic tail);
    int unsigned gap;
    gap = pick_gap(idle_pct);
    if (gap != 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= range_mm;
    s_tuser_i  <= ok;
    s_tlast_i  <= tail;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
  endtask

  // stop the stream and let the rotator empty out
  task automatic settle();
    s_tvalid_i <= 1'b0;
    // wait for the clock edge so the last accepted request is already noted
    @(posedge clk_i);
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    tracker.set_reg(idx, val);
  endtask

  // all five registers plus a stray write that must be ignored
  task automatic load_settings(input logic [15:0] sa, input logic [15:0] st,
                               input logic [15:0] sb, input logic [15:0] mn,
                               input logic [15:0] mx);
    put_reg(REG_START_ANGLE, sa);
    put_reg(REG_ANGLE_STEP, st);
    put_reg(REG_SECTOR_BOUND, sb);
    put_reg(REG_MIN_RANGE, mn);
    put_reg(REG_MAX_RANGE, mx);
    put_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 16'($urandom()));
    cfg_we_i <= 1'b0;
    settings_loaded++;
  endtask

  // mostly distances inside the window, some on its edges, some anywhere
  task automatic random_ray();
    logic [15:0] range_mm;
    int unsigned pick;
    int unsigned mn;
    int unsigned mx;
    mn   = tracker.min_range;
    mx   = tracker.max_range;
    pick = $urandom_range(99);
    if (pick < 70 && mx > mn + 1) begin
      range_mm = 16'($urandom_range(mn + 1, mx - 1));
    end else if (pick < 82) begin
      case ($urandom_range(5))
        0: range_mm = 16'h0000;
        1: range_mm = 16'hffff;
        2: range_mm = 16'(mn);
        3: range_mm = 16'(mn + 1);
        4: range_mm = 16'(mx);
        default: range_mm = 16'(mx - 1);
      endcase
    end else begin
      range_mm = 16'($urandom());
    end
    send_ray(range_mm, $urandom_range(15) != 0, $urandom_range(39) == 0);
  endtask

  task automatic run_phase(input int unsigned p);
    logic [15:0] mn;
    settle();
    mn = 16'($urandom_range(0, 20000));
    case (p)
      0: load_settings(START_ANGLE_RST, ANGLE_STEP_RST, SECTOR_BOUND_RST, MIN_RANGE_RST,
                       MAX_RANGE_RST);
      // only the exact half turn survives
      1: load_settings(16'h8000, 16'd91, 16'd32768, 16'd0, 16'hffff);
      // whole circle open
      2: load_settings(16'($urandom()), 16'($urandom()), 16'd0, 16'd0, 16'hffff);
      // bound beyond a half turn drops everything
      3: load_settings(16'($urandom()), 16'($urandom()), 16'hffff, mn, 16'hffff);
      // empty range window
      4: load_settings(16'h8000, 16'd91, 16'd0, 16'd5000, 16'd5000);
      5: load_settings(16'h7fff, 16'h8000, 16'd16384, 16'd0, 16'hffff);
      // fixed angle, no stepping
      6: load_settings(16'($urandom()), 16'd0, 16'($urandom_range(0, 32768)), mn, 16'hffff);
      // small steps so long scans wrap the angle
      7: load_settings(16'($urandom()), 16'($urandom_range(1, 700)),
                       16'($urandom_range(0, 32768)), 16'd0, 16'($urandom_range(30000, 65535)));
      default: load_settings(16'($urandom()), 16'($urandom()), 16'($urandom_range(0, 32768)),
                             mn, 16'($urandom_range(mn, 65535)));
    endcase
    case (p % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 20; stall_pct = 20; end
      2: begin idle_pct = 50; stall_pct = 10; end
      default: begin idle_pct = 10; stall_pct = 50; end
    endcase
    repeat (PHASE_LEN) random_ray();
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: range edges, an invalid reading, a scan end
    send_ray(16'd0, 1'b1, 1'b0);
    send_ray(16'd120, 1'b1, 1'b0);
    send_ray(16'd121, 1'b1, 1'b0);
    send_ray(16'd11999, 1'b1, 1'b0);
    send_ray(16'd12000, 1'b1, 1'b0);
    send_ray(16'hffff, 1'b1, 1'b0);
    send_ray(16'd5000, 1'b0, 1'b0);
    send_ray(16'd5000, 1'b1, 1'b1);
    send_ray(16'd5000, 1'b1, 1'b0);

    // quarter-turn steps at full range: saturation and offset wrap
    settle();
    load_settings(16'h8000, 16'd16384, 16'd0, 16'd0, 16'hffff);
    repeat (4) send_ray(16'hfffe, 1'b1, 1'b0);
    send_ray(16'hfffe, 1'b1, 1'b1);
    send_ray(16'd1, 1'b1, 1'b0);

    // either side of the quarter turn where the half-turn fold kicks in
    settle();
    load_settings(16'd16383, 16'd1, 16'd0, 16'd0, 16'hffff);
    repeat (3) send_ray(16'd40000, 1'b1, 1'b0);
    send_ray(16'd40000, 1'b1, 1'b1);

    // bound of exactly a half turn across the +180/-180 wrap
    settle();
    load_settings(16'h7fff, 16'd1, 16'd32768, 16'd0, 16'hffff);
    repeat (3) send_ray(16'd30000, 1'b1, 1'b0);

    for (int unsigned p = 0; p < N_PHASES; p++) run_phase(p);

    settle();
    $display("checked %0d points under %0d register settings: %0d kept, %0d scan ends",
             tracker.checked, settings_loaded, tracker.kept, tracker.scans);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("[scan_sector_to_points_core] OK");
    end else begin
      $display("[scan_sector_to_points_core] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("timeout with %0d points still due", tracker.outstanding());
    $display("[scan_sector_to_points_core] ERROR");
    $finish;
  end

endmodule

FILE: scan_sector_to_points_core.f
design/sstp_pkg.sv
design/sstp_front.sv
design/sstp_cell.sv
design/sstp_finish.sv
design/scan_sector_to_points_core.sv
sim/testbench.sv
